### rtl/bba_pkg.sv
// Shared types, constants and helper functions for the bitmap block allocator.
// Depends on nothing; every other file imports it.
package bba_pkg;

    localparam int NUM_BLOCKS = 512;
    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
    localparam int ADDR_W     = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int BLK_W      = 9;
    localparam int CNT_W      = 10;
    localparam int SUM_W      = CNT_W + 1;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_BLOCKS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] new_word;
        logic              has_free;
        logic [BIT_W-1:0]  free_bit;
    } word_res_t;

    // Index of the lowest clear bit of a word; zero when the word is full.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/bba_map_ram.sv
// Bitmap store: sixteen 32-bit words, one read and one write port, registered read.
// Depends on bba_pkg. Rows never written read as all free.
module bba_map_ram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [bba_pkg::ADDR_W-1:0]  rd_addr,
    output logic [bba_pkg::WORD_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [bba_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [bba_pkg::WORD_W-1:0]  wr_data
);
    import bba_pkg::*;

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [WORD_W-1:0]    rd_word_reg;
    logic [NUM_WORDS-1:0] row_valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // One valid bit per row stands in for clearing the array at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

### rtl/bba_word_mod.sv
// Applies the range mask to one bitmap word and finds its lowest free bit.
// Depends on bba_pkg.
module bba_word_mod (
    input  logic [bba_pkg::ADDR_W-1:0] word_idx,
    input  logic [bba_pkg::WORD_W-1:0] old_word,
    input  logic                       set_used,
    input  logic [bba_pkg::BLK_W-1:0]  range_lo,
    input  logic [bba_pkg::CNT_W-1:0]  range_hi,
    output bba_pkg::word_res_t         res
);
    import bba_pkg::*;

    logic [CNT_W-BIT_W-1:0] lo_word;
    logic [CNT_W-BIT_W-1:0] hi_word;
    logic [CNT_W-BIT_W-1:0] cur_word;
    logic [WORD_W-1:0]      lo_mask;
    logic [WORD_W-1:0]      hi_mask;
    logic [WORD_W-1:0]      mask;

    assign lo_word  = (CNT_W-BIT_W)'(range_lo[BLK_W-1:BIT_W]);
    assign hi_word  = range_hi[CNT_W-1:BIT_W];
    assign cur_word = (CNT_W-BIT_W)'(word_idx);

    always_comb
    begin
        if (cur_word > lo_word)
        begin
            lo_mask = '1;
        end
        else if (cur_word == lo_word)
        begin
            lo_mask = {WORD_W{1'b1}} << range_lo[BIT_W-1:0];
        end
        else
        begin
            lo_mask = '0;
        end

        if (cur_word < hi_word)
        begin
            hi_mask = '1;
        end
        else if (cur_word == hi_word)
        begin
            hi_mask = (WORD_W'(1) << range_hi[BIT_W-1:0]) - WORD_W'(1);
        end
        else
        begin
            hi_mask = '0;
        end

        mask = lo_mask & hi_mask;
        res.new_word = set_used ? (old_word | mask) : (old_word & ~mask);
        res.has_free = ~&res.new_word;
        res.free_bit = lowest_zero(res.new_word);
    end

endmodule

### rtl/bitmap_block_allocator.sv
// Bitmap block allocator: 512 blocks held as 16 words of 32 bits in one RAM.
// done pulses in ST_REPORT, once the walk over all 16 words is through.
// No new item is taken before the block is back in ST_IDLE; the walk over 16 words,
// one read port word per cycle through the registered read, sets how long it is busy.
// Reset: asynchronous, active low; every block free and the count at 512 at once.
// The receiver cannot stall: each result beat is shown for one cycle only.
module bitmap_block_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  func,
    input  logic [bba_pkg::BLK_W-1:0]   start_block,
    input  logic [bba_pkg::CNT_W-1:0]   block_count,
    output logic                        done,
    output logic                        block_used,
    output logic signed [bba_pkg::CNT_W-1:0] first_free,
    output logic [bba_pkg::CNT_W-1:0]   free_count,
    output logic                        range_clipped
);
    import bba_pkg::*;

    state_t state_reg, state_next;

    // Item held for the whole walk over the bitmap.
    logic                set_reg;
    logic [BLK_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic                clip_reg, clip_next;
    logic [CNT_W-1:0]    free_reg, free_next;

    // Word counter: reads go out while it is below 16, write-backs trail by one.
    logic [ADDR_W:0]     cnt_reg, cnt_next;

    logic                ff_found_reg, ff_found_next;
    logic [CNT_W-1:0]    ff_reg, ff_next;
    logic                used_reg, used_next;

    logic                accept;
    logic                is_update;
    logic [SUM_W-1:0]    end_full;
    logic [CNT_W-1:0]    end_clip;
    logic [CNT_W-1:0]    n_blocks;
    logic [SUM_W-1:0]    free_sum;

    logic                rd_en;
    logic [WORD_W-1:0]   rd_data;
    logic                proc_valid;
    logic [ADDR_W-1:0]   proc_idx;
    word_res_t           wres;

    assign accept    = start && !busy;
    assign is_update = (func == FUNC_ALLOC) || (func == FUNC_FREE);

    // Range end, clipped to the end of the map; queries and the spare code get an empty range.
    always_comb
    begin
        end_full = SUM_W'(start_block) + SUM_W'(block_count);
        if (is_update && (end_full > SUM_W'(NUM_BLOCKS)))
        begin
            clip_next = 1'b1;
            end_clip  = FULL_COUNT;
        end
        else if (is_update)
        begin
            clip_next = 1'b0;
            end_clip  = end_full[CNT_W-1:0];
        end
        else
        begin
            clip_next = 1'b0;
            end_clip  = CNT_W'(start_block);
        end
        n_blocks = end_clip - CNT_W'(start_block);

        // The count moves by the range length whatever the bits held, saturating.
        free_sum = SUM_W'(free_reg) + SUM_W'(n_blocks);
        if (!accept)
        begin
            free_next = free_reg;
        end
        else if (func == FUNC_ALLOC)
        begin
            free_next = (free_reg > n_blocks) ? (free_reg - n_blocks) : '0;
        end
        else if (func == FUNC_FREE)
        begin
            free_next = (free_sum > SUM_W'(NUM_BLOCKS)) ? FULL_COUNT
                                                         : free_sum[CNT_W-1:0];
        end
        else
        begin
            free_next = free_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == (ADDR_W+1)'(NUM_WORDS))
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        busy       = 1'b1;
        done       = 1'b0;
        rd_en      = 1'b0;
        proc_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en      = !cnt_reg[ADDR_W];
                proc_valid = (cnt_reg != '0);
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign proc_idx = ADDR_W'(cnt_reg - (ADDR_W+1)'(1));

    // Result gathering while the words stream back.
    always_comb
    begin
        cnt_next      = cnt_reg;
        ff_found_next = ff_found_reg;
        ff_next       = ff_reg;
        used_next     = used_reg;
        if (accept)
        begin
            cnt_next      = '0;
            ff_found_next = 1'b0;
            ff_next       = '1;
            used_next     = 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            cnt_next = cnt_reg + (ADDR_W+1)'(1);
        end

        if (proc_valid)
        begin
            if (!ff_found_reg && wres.has_free)
            begin
                ff_found_next = 1'b1;
                ff_next       = CNT_W'({proc_idx, wres.free_bit});
            end
            if (proc_idx == lo_reg[BLK_W-1:BIT_W])
            begin
                used_next = wres.new_word[lo_reg[BIT_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            free_reg     <= FULL_COUNT;
            ff_found_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            free_reg     <= free_next;
            ff_found_reg <= ff_found_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg  <= (func == FUNC_ALLOC);
            lo_reg   <= start_block;
            hi_reg   <= end_clip;
            clip_reg <= clip_next;
        end
        ff_reg   <= ff_next;
        used_reg <= used_next;
    end

    bba_map_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (proc_valid),
        .wr_addr (proc_idx),
        .wr_data (wres.new_word)
    );

    bba_word_mod u_mod (
        .word_idx (proc_idx),
        .old_word (rd_data),
        .set_used (set_reg),
        .range_lo (lo_reg),
        .range_hi (hi_reg),
        .res      (wres)
    );

    assign block_used    = used_reg;
    assign first_free    = ff_reg;
    assign free_count    = free_reg;
    assign range_clipped = clip_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for the bitmap block allocator: directed and random items,
// each result checked field by field against an in-bench model of the bitmap.
// Depends on rtl/bba_pkg.sv and rtl/bitmap_block_allocator.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    // The package names only the two range operations; the query code and the
    // spare code are named here so that no bare operation literal appears below.
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // The block shows a result only at the end of its walk over the map, and a margin
    // at the end that outlasts that walk covers any beat still in flight.
    localparam int SETTLE_CYCLES = 40;
    // Roughly 450 items, each taking its walk over the map plus at most the longest
    // sender gap, stay far below this figure.
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic                    block_used;
        logic [CNT_W-1:0]        first_free;
        logic [CNT_W-1:0]        free_count;
        logic                    range_clipped;
    } alloc_result_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               func = FUNC_QUERY;
    logic [BLK_W-1:0]         start_block = '0;
    logic [CNT_W-1:0]         block_count = '0;
    logic                     done;
    logic                     block_used;
    logic signed [CNT_W-1:0]  first_free;
    logic [CNT_W-1:0]         free_count;
    logic                     range_clipped;

    // Model state: one bit per block (1 means used) and the running free count.
    logic                     used_blocks [NUM_BLOCKS];
    int                       free_blocks;

    alloc_result_t            pending_results [$];
    int                       mismatch_count = 0;
    int                       cycle_count = 0;

    bitmap_block_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .start_block   (start_block),
        .block_count   (block_count),
        .done          (done),
        .block_used    (block_used),
        .first_free    (first_free),
        .free_count    (free_count),
        .range_clipped (range_clipped)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Applies one operation to the model bitmap and returns what the block
    // should report for it. Allocate and free touch only blocks below the
    // end of the map; the count moves by one for every block touched, whether
    // or not its bit changed, and saturates at both ends.
    function automatic alloc_result_t apply_bitmap_op(input logic [1:0] op,
                                                      input int first_blk,
                                                      input int length);
        alloc_result_t res;
        int            last_blk;
        int            touched;
        res.range_clipped = 1'b0;
        if (op == FUNC_ALLOC || op == FUNC_FREE)
        begin
            last_blk = first_blk + length;
            if (last_blk > NUM_BLOCKS)
            begin
                res.range_clipped = 1'b1;
                last_blk = NUM_BLOCKS;
            end
            touched = (last_blk > first_blk) ? last_blk - first_blk : 0;
            for (int b = first_blk; b < last_blk; b++)
            begin
                used_blocks[b] = (op == FUNC_ALLOC);
            end
            if (op == FUNC_ALLOC)
            begin
                free_blocks = (free_blocks > touched) ? free_blocks - touched : 0;
            end
            else
            begin
                free_blocks = free_blocks + touched;
                if (free_blocks > NUM_BLOCKS)
                begin
                    free_blocks = NUM_BLOCKS;
                end
            end
        end
        res.block_used = (first_blk < NUM_BLOCKS) ? used_blocks[first_blk] : 1'b0;
        // All ones stands for "no free block".
        res.first_free = '1;
        for (int b = NUM_BLOCKS - 1; b >= 0; b--)
        begin
            if (!used_blocks[b])
            begin
                res.first_free = CNT_W'(b);
            end
        end
        res.free_count = CNT_W'(free_blocks);
        return res;
    endfunction

    task automatic report_mismatch(input string field_name, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d",
                 $realtime, field_name, got, want);
        mismatch_count++;
    endtask

    // Result checker. done marks a beat that lasts exactly one cycle and is
    // taken at the rising edge that ends it; values read here are the ones
    // from before the edge, since the block updates them by nonblocking
    // assignment.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (block_used !== want.block_used)
                begin
                    report_mismatch("block_used", block_used, want.block_used);
                end
                if (first_free !== want.first_free)
                begin
                    report_mismatch("first_free", first_free, $signed(want.first_free));
                end
                if (free_count !== want.free_count)
                begin
                    report_mismatch("free_count", free_count, want.free_count);
                end
                if (range_clipped !== want.range_clipped)
                begin
                    report_mismatch("range_clipped", range_clipped, want.range_clipped);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_block_allocator regression: fail");
            $finish;
        end
    end

    // Sends one item. It is entered just after a falling edge and returns just
    // after the falling edge that follows acceptance, with start still high,
    // so that a following item can go out back to back without start being
    // lowered and raised in the same step.
    task automatic send_op(input logic [1:0] op, input int first_blk, input int length);
        alloc_result_t want;
        start       <= 1'b1;
        func        <= op;
        start_block <= BLK_W'(first_blk);
        block_count <= CNT_W'(length);
        do
        begin
            @(posedge clk);
        end
        while (busy);
        // The beat was taken at this edge, so the model moves on with it.
        want = apply_bitmap_op(op, first_blk, length);
        pending_results = {pending_results, want};
        @(negedge clk);
    endtask

    // Holds the sender off for some cycles, with noise on the payload ports
    // to show that they are ignored while start is low.
    task automatic hold_sender(input int cycles);
        if (cycles > 0)
        begin
            start       <= 1'b0;
            func        <= 2'($urandom);
            start_block <= BLK_W'($urandom);
            block_count <= CNT_W'($urandom);
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Mostly no gap or a short one, now and then a long one, so that against the
    // block's busy time per item the gaps land on every phase of its walk.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        else if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(21, 60);
    endfunction

    task automatic wait_until_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Extremes of every field, every operation code and each corner named in
    // the block's description: empty range, full map, clipping, saturation of
    // the count at both ends and the spare operation code.
    task automatic test_directed_corners();
        send_op(FUNC_QUERY, 0, 0);
        send_op(FUNC_QUERY, NUM_BLOCKS - 1, 1023);
        send_op(FUNC_ALLOC, 0, 0);
        send_op(FUNC_FREE, 7, 0);
        send_op(FUNC_ALLOC, 0, 1);
        send_op(FUNC_ALLOC, NUM_BLOCKS - 1, 1);
        send_op(FUNC_FREE, 0, 1);
        // Whole map used: no free block remains and the count reaches zero.
        send_op(FUNC_ALLOC, 0, NUM_BLOCKS);
        send_op(FUNC_ALLOC, 100, 50);
        send_op(FUNC_FREE, NUM_BLOCKS - 1, 1);
        send_op(FUNC_ALLOC, 500, 20);
        send_op(FUNC_SPARE, 3, 400);
        send_op(FUNC_FREE, 0, NUM_BLOCKS);
        // Freeing blocks that are already free drives the count against its ceiling.
        send_op(FUNC_FREE, 256, 256);
        send_op(FUNC_FREE, 511, 1023);
        send_op(FUNC_ALLOC, 300, 1023);
        send_op(FUNC_QUERY, 299, 5);
        send_op(FUNC_QUERY, 300, 0);
        send_op(FUNC_SPARE, NUM_BLOCKS - 1, 0);
        send_op(FUNC_ALLOC, 0, 511);
        send_op(FUNC_FREE, 128, 1);
        send_op(FUNC_ALLOC, 255, 257);
        send_op(FUNC_FREE, 0, 1023);
    endtask

    // The sender stops until every expected result has come back, then goes on.
    task automatic test_drain_pause();
        send_op(FUNC_ALLOC, $urandom_range(0, 511), $urandom_range(1, 64));
        send_op(FUNC_QUERY, $urandom_range(0, 511), 0);
        wait_until_drained();
        hold_sender($urandom_range(1, 5));
        send_op(FUNC_FREE, $urandom_range(0, 511), $urandom_range(1, 64));
    endtask

    // Well-formed sequences: the map is filled in consecutive chunks up to the
    // top, from block 0 or now and then from a random point, and a chunk of random
    // length is then taken from block 0; then blocks are freed again in random
    // pieces. Queries at random blocks are mixed in.
    task automatic test_fill_and_drain(input int items);
        int sent;
        int pos;
        int chunk;
        sent = 0;
        while (sent < items)
        begin
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : 0;
            while (pos < NUM_BLOCKS && sent < items)
            begin
                chunk = $urandom_range(1, 64);
                send_op(FUNC_ALLOC, pos, chunk);
                hold_sender(pick_gap());
                sent++;
                pos += chunk;
                if ($urandom_range(0, 4) == 0)
                begin
                    send_op(FUNC_QUERY, $urandom_range(0, 511), $urandom_range(0, 1023));
                    sent++;
                end
            end
            send_op(FUNC_ALLOC, 0, $urandom_range(1, 512));
            sent++;
            repeat ($urandom_range(8, 20))
            begin
                send_op(FUNC_FREE, $urandom_range(0, 511), $urandom_range(1, 96));
                hold_sender(pick_gap());
                sent++;
            end
        end
    endtask

    // Unstructured traffic: all four codes, mostly short ranges, a few long
    // ones that clip, starts biased now and then towards the top of the map.
    task automatic test_random_mix(input int items);
        int          roll;
        logic [1:0]  op;
        int          first_blk;
        int          length;
        for (int k = 0; k < items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                op = FUNC_ALLOC;
            end
            else if (roll < 75)
            begin
                op = FUNC_FREE;
            end
            else if (roll < 92)
            begin
                op = FUNC_QUERY;
            end
            else
            begin
                op = FUNC_SPARE;
            end
            first_blk = ($urandom_range(0, 4) == 0) ? $urandom_range(448, 511)
                                                    : $urandom_range(0, 511);
            length    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 40);
            send_op(op, first_blk, length);
            // A stretch in the middle goes out back to back with no gaps.
            if (k < items / 3 || k > items / 3 + 30)
            begin
                hold_sender(pick_gap());
            end
        end
    endtask

    initial
    begin
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            used_blocks[b] = 1'b0;
        end
        free_blocks = NUM_BLOCKS;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_drain_pause();
        test_random_mix(200);
        test_fill_and_drain(210);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("bitmap_block_allocator regression: pass");
        end
        else
        begin
            $display("bitmap_block_allocator regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_word_mod.sv
rtl/bitmap_block_allocator.sv
tb/testbench.sv
